// ----- design/uqt_pkg.sv -----
`default_nettype none
package uqt_pkg;

    typedef enum logic [3:0] {
        OP_RESERVE     = 4'd0,
        OP_RELEASE     = 4'd1,
        OP_TRANSFER    = 4'd2,
        OP_REBUILD     = 4'd3,
        OP_SET_USER    = 4'd4,
        OP_SET_GROUP   = 4'd5,
        OP_GET_USER    = 4'd6,
        OP_GET_GROUP   = 4'd7,
        OP_UNDO_RES    = 4'd8,
        OP_UNDO_XFER   = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_QUOTA   = 3'd3,
        ST_ACCOUNT = 3'd4
    } status_t;

    localparam logic [1:0] CFG_USER_ENF  = 2'd0;
    localparam logic [1:0] CFG_GROUP_ENF = 2'd1;
    localparam logic [1:0] CFG_GRACE     = 2'd2;
    localparam logic [63:0] GRACE_RESET  = 64'd604800;

    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] user_id;
        logic [31:0] group_id;
        logic [31:0] new_user_id;
        logic [31:0] new_group_id;
        logic [63:0] block_count;
        logic [63:0] inode_count;
        logic [63:0] time_now;
        logic [63:0] soft_blocks;
        logic [63:0] hard_blocks;
        logic [63:0] soft_inodes;
        logic [63:0] hard_inodes;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        record_found;
        logic [63:0] used_blocks;
        logic [63:0] used_inodes;
        logic [63:0] out_soft_blocks;
        logic [63:0] out_hard_blocks;
        logic [63:0] out_soft_inodes;
        logic [63:0] out_hard_inodes;
        logic [63:0] block_deadline;
        logic [63:0] inode_deadline;
    } out_item_t;

    // one stored record (id held apart in flops)
    typedef struct packed {
        logic [63:0] ub;
        logic [63:0] ui;
        logic [63:0] sb;
        logic [63:0] hb;
        logic [63:0] si;
        logic [63:0] hi;
        logic [63:0] db;
        logic [63:0] di;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_WAIT,
        S_EVAL,
        S_WRITE,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- design/uqt_search.sv -----
`default_nettype none
// Id lookup over the slot directory, one slot per cycle.
module uqt_search #(
    parameter int SLOTS = 32,
    parameter int AW = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            kind,
    input  wire logic [31:0]     id,
    input  wire logic            write_en,
    input  wire logic [AW-1:0]   write_slot,
    input  wire logic [31:0]     write_id,
    output logic                 done,
    output logic                 found,
    output logic                 has_free,
    output logic [AW-1:0]        hit_slot,
    output logic [AW-1:0]        free_slot
);
    localparam int PER = SLOTS / 2;
    localparam int PW = (PER > 1) ? $clog2(PER) : 1;

    logic [SLOTS-1:0] valid_reg;
    logic [31:0]      id_reg [SLOTS];
    logic             busy_reg;
    logic [PW:0]      cnt_reg;
    logic             found_reg, free_ok_reg;
    logic [AW-1:0]    hit_reg, free_reg;
    logic [AW-1:0]    cur;

    assign cur = AW'(kind ? PER : 0) + AW'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            if (write_en)
                valid_reg[write_slot] <= 1'b1;
            if (start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (valid_reg[cur] && id_reg[cur] == id && !found_reg)
                    found_reg <= 1'b1;
                if (!valid_reg[cur] && !free_ok_reg)
                    free_ok_reg <= 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == (PW+1)'(PER - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
            id_reg[write_slot] <= write_id;
        if (busy_reg && !start)
        begin
            if (valid_reg[cur] && id_reg[cur] == id && !found_reg)
                hit_reg <= cur;
            if (!valid_reg[cur] && !free_ok_reg)
                free_reg <= cur;
        end
    end

    logic busy_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_d_reg <= 1'b0;
        else
            busy_d_reg <= busy_reg;
    end

    assign done      = busy_d_reg && !busy_reg;
    assign found     = found_reg;
    assign has_free  = free_ok_reg;
    assign hit_slot  = hit_reg;
    assign free_slot = free_reg;
endmodule
`default_nettype wire

// ----- design/usage_quota_table.sv -----
`default_nettype none
// Usage quota table: user and group usage records kept in one record memory.
// Input channel in_valid/in_stall/in_data carries one operation per transaction;
// output channel out_valid/out_stall/out_data returns exactly one status
// transaction per operation (record fields filled only for a get).
// Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// enforce flags and grace period; it is always ready.
// Each operation first resolves up to four ids in turn; each lookup walks one table
// of RECORDS_PER_TYPE slots, one slot a cycle. Each record is then read from the
// registered-read memory and evaluated in a check pass, then read again and written back.
// Operations are processed one at a time; in_stall is high while busy.
// The result sits in an output register; a new input is taken while it
// waits, but its result is held back until the old one is taken.
// Reset clears all slot valid bits; record memory contents need no reset.
module usage_quota_table #(
    parameter int RECORDS_PER_TYPE = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire uqt_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output uqt_pkg::out_item_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);
    import uqt_pkg::*;

    localparam int SLOTS = 2 * RECORDS_PER_TYPE;
    localparam int AW = $clog2(SLOTS);

    logic        user_enf_reg, group_enf_reg;
    logic [63:0] grace_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_enf_reg  <= 1'b0;
            group_enf_reg <= 1'b0;
            grace_reg     <= GRACE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_USER_ENF:  user_enf_reg  <= cfg_data[0];
                CFG_GROUP_ENF: group_enf_reg <= cfg_data[0];
                CFG_GRACE:     if (cfg_data != '0) grace_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // record memory
    rec_t          mem [SLOTS];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    rec_t          mem_wdata, mem_rdata_reg;
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_addr];
    end

    // operation context
    state_t      state_reg, state_next;
    in_item_t    it_reg;
    logic [1:0]  step_reg, step_next;   // 0 ou/u (g for group set/get), 1 og/g, 2 nu, 3 ng
    logic        phase_reg, phase_next; // 0 lookups, 1 check and apply passes
    logic [3:0]  ex_reg, ex_next;        // slot exists
    logic [3:0]  nw_reg, nw_next;        // slot freshly created
    logic [AW-1:0] sl_reg [4];
    logic [AW-1:0] sl_next [4];
    logic [2:0]  st_reg, st_next;
    rec_t        rec_reg, rec_next;
    out_item_t   res_reg, res_next;
    logic        res_pend_reg, res_pend_next;
    logic        ov_reg, ov_next;
    out_item_t   od_reg, od_next;
    logic        fl_reg, fl_next;        // get found

    // search unit
    logic          s_start, s_kind, s_done, s_found, s_free, s_we;
    logic [31:0]   s_id;
    logic [AW-1:0] s_hit, s_fslot;
    uqt_search #(.SLOTS(SLOTS), .AW(AW)) u_search (
        .clk(clk), .rst_n(rst_n), .start(s_start), .kind(s_kind), .id(s_id),
        .write_en(s_we), .write_slot(s_fslot), .write_id(s_id),
        .done(s_done), .found(s_found), .has_free(s_free),
        .hit_slot(s_hit), .free_slot(s_fslot)
    );

    op_t op;
    assign op = op_t'(it_reg.operation);
    logic ud, gd;
    assign ud = it_reg.user_id != it_reg.new_user_id;
    assign gd = it_reg.group_id != it_reg.new_group_id;

    // per-step: id, table, create?
    always_comb
    begin
        case (step_reg)
            2'd0: s_id = (op == OP_SET_GROUP || op == OP_GET_GROUP) ?
                         it_reg.group_id : it_reg.user_id;
            2'd1: s_id = it_reg.group_id;
            2'd2: s_id = it_reg.new_user_id;
            default: s_id = it_reg.new_group_id;
        endcase
        s_kind = (step_reg == 2'd1) || (step_reg == 2'd3) ||
                 (step_reg == 2'd0 && (op == OP_SET_GROUP || op == OP_GET_GROUP));
    end

    logic create;
    always_comb
    begin
        case (op)
            OP_RESERVE, OP_REBUILD, OP_SET_USER, OP_SET_GROUP: create = 1'b1;
            OP_TRANSFER:  create = step_reg[1];
            OP_UNDO_XFER: create = !step_reg[1];
            default:      create = 1'b0;
        endcase
    end

    logic [1:0] nsteps; // last step index
    always_comb
    begin
        case (op)
            OP_TRANSFER, OP_UNDO_XFER: nsteps = 2'd3;
            OP_SET_USER, OP_SET_GROUP, OP_GET_USER, OP_GET_GROUP: nsteps = 2'd0;
            default: nsteps = 2'd1;
        endcase
    end

    // block count, inode count and time of the current operation
    logic [63:0] b, n, now;
    assign b = it_reg.block_count;
    assign n = it_reg.inode_count;
    assign now = it_reg.time_now;

    function automatic logic chk(input rec_t r, input logic [63:0] bb, input logic [63:0] nn,
                                 input logic [63:0] tn);
        logic [64:0] sb_, si_;
        logic [63:0] nb, ni;
        logic q;
        begin
            sb_ = {1'b0, r.ub} + {1'b0, bb};
            si_ = {1'b0, r.ui} + {1'b0, nn};
            nb = sb_[63:0];
            ni = si_[63:0];
            q = sb_[64] || si_[64] ||
                (r.hb != '0 && nb > r.hb) || (r.hi != '0 && ni > r.hi) ||
                (r.sb != '0 && nb > r.sb && r.db != '0 && tn >= r.db) ||
                (r.si != '0 && ni > r.si && r.di != '0 && tn >= r.di);
            chk = q;
        end
    endfunction

    function automatic rec_t addr_(input rec_t r, input logic [63:0] bb, input logic [63:0] nn,
                                   input logic [63:0] tn, input logic [63:0] gp);
        rec_t o;
        begin
            o = r;
            o.ub = r.ub + bb;
            o.ui = r.ui + nn;
            if (o.sb != '0 && o.ub > o.sb && o.db == '0) o.db = tn + gp;
            if (o.si != '0 && o.ui > o.si && o.di == '0) o.di = tn + gp;
            addr_ = o;
        end
    endfunction

    function automatic rec_t subr(input rec_t r, input logic [63:0] bb, input logic [63:0] nn);
        rec_t o;
        begin
            o = r;
            o.ub = r.ub - bb;
            o.ui = r.ui - nn;
            if (o.sb == '0 || o.ub <= o.sb) o.db = '0;
            if (o.si == '0 || o.ui <= o.si) o.di = '0;
            subr = o;
        end
    endfunction

    logic holds_r;
    assign holds_r = rec_reg.ub >= b && rec_reg.ui >= n;
    logic [64:0] ovb, ovi;
    assign ovb = {1'b0, rec_reg.ub} + {1'b0, b};
    assign ovi = {1'b0, rec_reg.ui} + {1'b0, n};

    // does the apply phase touch step s
    logic touch;
    always_comb
    begin
        case (op)
            OP_RESERVE, OP_REBUILD, OP_UNDO_RES, OP_RELEASE: touch = ex_reg[step_reg];
            OP_SET_USER, OP_SET_GROUP, OP_GET_USER, OP_GET_GROUP: touch = ex_reg[0];
            default: touch = step_reg[0] ? gd : ud;
        endcase
    end

    logic is_check_phase;
    // phase 1 pass 0 checks (no write), pass 1 applies; encoded by ph2
    logic ph2_reg, ph2_next;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        ph2_next      = ph2_reg;
        ex_next       = ex_reg;
        nw_next       = nw_reg;
        for (int k = 0; k < 4; k++) sl_next[k] = sl_reg[k];
        st_next       = st_reg;
        rec_next      = rec_reg;
        res_next      = res_reg;
        res_pend_next = res_pend_reg;
        fl_next       = fl_reg;
        ov_next       = ov_reg;
        od_next       = od_reg;
        s_start  = 1'b0;
        s_we     = 1'b0;
        mem_we   = 1'b0;
        mem_addr = sl_reg[step_reg];
        mem_wdata = rec_reg;
        in_stall = (state_reg != S_IDLE) || res_pend_reg;
        is_check_phase = !ph2_reg;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    st_next = ST_OK;
                    ex_next = '0;
                    nw_next = '0;
                    step_next = 2'd0;
                    phase_next = 1'b0;
                    ph2_next = 1'b0;
                    fl_next = 1'b0;
                    res_next = '0;
                    if (in_data.operation > 4'd9 ||
                        ((in_data.operation == 4'd4 || in_data.operation == 4'd5) &&
                         ((in_data.hard_blocks != '0 && in_data.soft_blocks > in_data.hard_blocks) ||
                          (in_data.hard_inodes != '0 && in_data.soft_inodes > in_data.hard_inodes))))
                    begin
                        st_next = ST_INVALID;
                        state_next = S_DONE;
                    end
                    else if (in_data.operation == 4'd2 &&
                             in_data.user_id == in_data.new_user_id &&
                             in_data.group_id == in_data.new_group_id)
                        state_next = S_DONE;
                    else
                        state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                s_start = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (s_done)
                begin
                    if (s_found)
                    begin
                        ex_next[step_reg] = 1'b1;
                        sl_next[step_reg] = s_hit;
                    end
                    else if (create && s_free)
                    begin
                        s_we = 1'b1;
                        ex_next[step_reg] = 1'b1;
                        nw_next[step_reg] = 1'b1;
                        sl_next[step_reg] = s_fslot;
                        mem_we = 1'b1;
                        mem_addr = s_fslot;
                        mem_wdata = '0;
                    end
                    if (step_reg == nsteps)
                    begin
                        step_next = 2'd0;
                        phase_next = 1'b1;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        step_next = step_reg + 2'd1;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_WAIT:
            begin
                // address presented, data next cycle
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                rec_next = mem_rdata_reg;
                state_next = S_WRITE;
                // status decided in the check pass, before the apply pass writes any record
            end
            S_WRITE:
            begin
                // rec_reg holds record at sl_reg[step_reg]
                if (!ph2_reg)
                begin
                    // check pass
                    case (op)
                        OP_RESERVE:
                        begin
                            if (!ex_reg[0] || !ex_reg[1]) st_next = ST_FULL;
                            else if (st_reg == ST_OK &&
                                     ((step_reg == 2'd0 && user_enf_reg) ||
                                      (step_reg == 2'd1 && group_enf_reg)) &&
                                     chk(rec_reg, b, n, now))
                                st_next = ST_QUOTA;
                        end
                        OP_REBUILD:
                            if (!ex_reg[0] || !ex_reg[1] || ovb[64] || ovi[64])
                                st_next = ST_FULL;
                        OP_RELEASE:
                            if ((step_reg == 2'd0 && user_enf_reg) ||
                                (step_reg == 2'd1 && group_enf_reg))
                                if (!ex_reg[step_reg] || !holds_r) st_next = ST_ACCOUNT;
                        OP_TRANSFER:
                        begin
                            if (ex_reg != 4'hF) st_next = ST_ACCOUNT;
                            else if (step_reg[1] == 1'b0 && !holds_r) st_next = ST_ACCOUNT;
                            else if (st_reg == ST_OK && step_reg == 2'd2 && ud &&
                                     user_enf_reg && chk(rec_reg, b, n, now))
                                st_next = ST_QUOTA;
                            else if (st_reg == ST_OK && step_reg == 2'd3 && gd &&
                                     group_enf_reg && chk(rec_reg, b, n, now))
                                st_next = ST_QUOTA;
                        end
                        OP_UNDO_XFER:
                        begin
                            // step 2/3 decide whether user/group pair moves
                            if (step_reg == 2'd2 && !(ud && ex_reg[0] && ex_reg[2] && holds_r))
                                ex_next[2] = 1'b0;
                            if (step_reg == 2'd3 && !(gd && ex_reg[1] && ex_reg[3] && holds_r))
                                ex_next[3] = 1'b0;
                        end
                        OP_GET_USER, OP_GET_GROUP:
                            if (ex_reg[0])
                            begin
                                fl_next = 1'b1;
                                res_next.record_found = 1'b1;
                                res_next.used_blocks = rec_reg.ub;
                                res_next.used_inodes = rec_reg.ui;
                                res_next.out_soft_blocks = rec_reg.sb;
                                res_next.out_hard_blocks = rec_reg.hb;
                                res_next.out_soft_inodes = rec_reg.si;
                                res_next.out_hard_inodes = rec_reg.hi;
                                res_next.block_deadline = rec_reg.db;
                                res_next.inode_deadline = rec_reg.di;
                            end
                        OP_SET_USER, OP_SET_GROUP:
                            if (!ex_reg[0]) st_next = ST_FULL;
                        default: ;
                    endcase
                    if (step_reg == nsteps)
                    begin
                        step_next = 2'd0;
                        ph2_next = 1'b1;
                    end
                    else
                        step_next = step_reg + 2'd1;
                    state_next = S_WAIT;
                end
                else
                begin
                    // apply pass
                    mem_addr = sl_reg[step_reg];
                    mem_wdata = rec_reg;
                    case (op)
                        OP_RESERVE:
                            if (st_reg == ST_OK)
                            begin
                                mem_we = 1'b1;
                                mem_wdata = addr_(rec_reg, b, n, now, grace_reg);
                            end
                        OP_REBUILD:
                            if (st_reg == ST_OK)
                            begin
                                mem_we = 1'b1;
                                mem_wdata.ub = rec_reg.ub + b;
                                mem_wdata.ui = rec_reg.ui + n;
                            end
                        OP_RELEASE, OP_UNDO_RES:
                            if (st_reg == ST_OK && ex_reg[step_reg])
                            begin
                                mem_we = 1'b1;
                                mem_wdata = subr(rec_reg, b, n);
                            end
                        OP_TRANSFER:
                            if (st_reg == ST_OK && touch)
                            begin
                                mem_we = 1'b1;
                                mem_wdata = step_reg[1] ?
                                    addr_(rec_reg, b, n, now, grace_reg) : subr(rec_reg, b, n);
                            end
                        OP_UNDO_XFER:
                            if (ex_reg[{1'b1, step_reg[0]}])
                            begin
                                mem_we = 1'b1;
                                mem_wdata = step_reg[1] ?
                                    subr(rec_reg, b, n) : addr_(rec_reg, b, n, now, grace_reg);
                            end
                        OP_SET_USER, OP_SET_GROUP:
                            if (ex_reg[0])
                            begin
                                mem_we = 1'b1;
                                mem_wdata.sb = it_reg.soft_blocks;
                                mem_wdata.hb = it_reg.hard_blocks;
                                mem_wdata.si = it_reg.soft_inodes;
                                mem_wdata.hi = it_reg.hard_inodes;
                                if (rec_reg.ub <= it_reg.soft_blocks || it_reg.soft_blocks == '0)
                                    mem_wdata.db = '0;
                                if (rec_reg.ui <= it_reg.soft_inodes || it_reg.soft_inodes == '0)
                                    mem_wdata.di = '0;
                            end
                        default: ;
                    endcase
                    if (step_reg == nsteps)
                        state_next = S_DONE;
                    else
                    begin
                        step_next = step_reg + 2'd1;
                        state_next = S_WAIT;
                    end
                end
            end
            S_DONE:
            begin
                res_next.status = st_reg;
                res_pend_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (res_pend_reg && (!ov_reg || !out_stall))
        begin
            ov_next = 1'b1;
            od_next = res_reg;
            res_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            res_pend_reg <= 1'b0;
            ov_reg       <= 1'b0;
            step_reg     <= '0;
            phase_reg    <= 1'b0;
            ph2_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_pend_reg <= res_pend_next;
            ov_reg       <= ov_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            ph2_reg      <= ph2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !in_stall)
            it_reg <= in_data;
        ex_reg  <= ex_next;
        nw_reg  <= nw_next;
        for (int k = 0; k < 4; k++) sl_reg[k] <= sl_next[k];
        st_reg  <= st_next;
        rec_reg <= rec_next;
        res_reg <= res_next;
        fl_reg  <= fl_next;
        od_reg  <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_pend_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> res_pend_reg) else $error("result lost");
endmodule
`default_nettype wire

// ----- tb/usage_quota_table_test.sv -----
`default_nettype none
module usage_quota_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import uqt_pkg::*;

    localparam int  NREC      = 16;
    localparam int  NSLOT     = 2 * NREC;
    localparam int  RAND_OPS  = 550;
    localparam int  SETTLE    = 4 * (NREC + 6) + 30;
    localparam longint CYCLE_LIMIT = 800000;
    localparam logic [63:0] MAX64 = '1;

    // Mirror of both record tables plus the config registers; turns each
    // accepted operation into its expected reply.
    class quota_ledger;
        bit          live[NSLOT];
        logic [31:0] owner[NSLOT];
        rec_t        rec[NSLOT];
        bit          user_enf;
        bit          group_enf;
        logic [63:0] grace;
        out_item_t   pending_replies[$];
        int          errors;
        int          replies_seen;
        int          refusals;
        int          reads_hit;

        function new();
            grace = GRACE_RESET;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            if (idx == CFG_USER_ENF)
                user_enf = val[0];
            else if (idx == CFG_GROUP_ENF)
                group_enf = val[0];
            else if (idx == CFG_GRACE && val != 0)
                grace = val;
        endfunction

        function int find(int kind, logic [31:0] id, bit create);
            int base;
            int spare;
            base = kind * NREC;
            spare = -1;
            for (int i = base; i < base + NREC; i++) begin
                if (live[i] && owner[i] == id)
                    return i;
                if (!live[i] && spare < 0)
                    spare = i;
            end
            if (!create || spare < 0)
                return -1;
            live[spare] = 1;
            owner[spare] = id;
            rec[spare] = '0;
            return spare;
        endfunction

        function status_t limit_check(int r, logic [63:0] b, logic [63:0] n, logic [63:0] now);
            logic [63:0] nb;
            logic [63:0] ni;
            if (b > ~rec[r].ub || n > ~rec[r].ui)
                return ST_QUOTA;
            nb = rec[r].ub + b;
            ni = rec[r].ui + n;
            if ((rec[r].hb != 0 && nb > rec[r].hb) || (rec[r].hi != 0 && ni > rec[r].hi))
                return ST_QUOTA;
            if (rec[r].sb != 0 && nb > rec[r].sb && rec[r].db != 0 && now >= rec[r].db)
                return ST_QUOTA;
            if (rec[r].si != 0 && ni > rec[r].si && rec[r].di != 0 && now >= rec[r].di)
                return ST_QUOTA;
            return ST_OK;
        endfunction

        function void charge(int r, logic [63:0] b, logic [63:0] n, logic [63:0] now);
            rec[r].ub += b;
            rec[r].ui += n;
            if (rec[r].sb != 0 && rec[r].ub > rec[r].sb && rec[r].db == 0)
                rec[r].db = now + grace;
            if (rec[r].si != 0 && rec[r].ui > rec[r].si && rec[r].di == 0)
                rec[r].di = now + grace;
        endfunction

        function void credit(int r, logic [63:0] b, logic [63:0] n);
            rec[r].ub -= b;
            rec[r].ui -= n;
            if (rec[r].sb == 0 || rec[r].ub <= rec[r].sb)
                rec[r].db = 0;
            if (rec[r].si == 0 || rec[r].ui <= rec[r].si)
                rec[r].di = 0;
        endfunction

        function bit covers(int r, logic [63:0] b, logic [63:0] n);
            return rec[r].ub >= b && rec[r].ui >= n;
        endfunction

        function void note_operation(in_item_t it);
            out_item_t   rep;
            status_t     st;
            int          u, g, ou, og, nu, ng, r;
            logic [63:0] b, n, now;
            rep = '0;
            st = ST_OK;
            b = it.block_count;
            n = it.inode_count;
            now = it.time_now;
            case (it.operation)
                OP_RESERVE: begin
                    u = find(0, it.user_id, 1);
                    g = find(1, it.group_id, 1);
                    if (u < 0 || g < 0)
                        st = ST_FULL;
                    if (st == ST_OK && user_enf)
                        st = limit_check(u, b, n, now);
                    if (st == ST_OK && group_enf)
                        st = limit_check(g, b, n, now);
                    if (st == ST_OK)
                    begin
                        charge(u, b, n, now);
                        charge(g, b, n, now);
                    end
                end
                OP_RELEASE: begin
                    u = find(0, it.user_id, 0);
                    g = find(1, it.group_id, 0);
                    if ((user_enf && (u < 0 || !covers(u, b, n))) ||
                        (group_enf && (g < 0 || !covers(g, b, n))))
                        st = ST_ACCOUNT;
                    else
                    begin
                        if (u >= 0)
                            credit(u, b, n);
                        if (g >= 0)
                            credit(g, b, n);
                    end
                end
                OP_TRANSFER: begin
                    if (!(it.user_id == it.new_user_id && it.group_id == it.new_group_id))
                    begin
                        ou = find(0, it.user_id, 0);
                        og = find(1, it.group_id, 0);
                        nu = find(0, it.new_user_id, 1);
                        ng = find(1, it.new_group_id, 1);
                        if (ou < 0 || og < 0 || nu < 0 || ng < 0)
                            st = ST_ACCOUNT;
                        else if (!covers(ou, b, n) || !covers(og, b, n))
                            st = ST_ACCOUNT;
                        if (st == ST_OK && it.user_id != it.new_user_id && user_enf)
                            st = limit_check(nu, b, n, now);
                        if (st == ST_OK && it.group_id != it.new_group_id && group_enf)
                            st = limit_check(ng, b, n, now);
                        if (st == ST_OK)
                        begin
                            if (it.user_id != it.new_user_id)
                            begin
                                credit(ou, b, n);
                                charge(nu, b, n, now);
                            end
                            if (it.group_id != it.new_group_id)
                            begin
                                credit(og, b, n);
                                charge(ng, b, n, now);
                            end
                        end
                    end
                end
                OP_REBUILD: begin
                    u = find(0, it.user_id, 1);
                    g = find(1, it.group_id, 1);
                    if (u < 0 || g < 0)
                        st = ST_FULL;
                    else if (b > ~rec[u].ub || b > ~rec[g].ub ||
                             n > ~rec[u].ui || n > ~rec[g].ui)
                        st = ST_FULL;
                    else
                    begin
                        rec[u].ub += b;
                        rec[u].ui += n;
                        rec[g].ub += b;
                        rec[g].ui += n;
                    end
                end
                OP_SET_USER, OP_SET_GROUP: begin
                    if ((it.hard_blocks != 0 && it.soft_blocks > it.hard_blocks) ||
                        (it.hard_inodes != 0 && it.soft_inodes > it.hard_inodes))
                        st = ST_INVALID;
                    else
                    begin
                        if (it.operation == OP_SET_USER)
                            r = find(0, it.user_id, 1);
                        else
                            r = find(1, it.group_id, 1);
                        if (r < 0)
                            st = ST_FULL;
                        else
                        begin
                            rec[r].sb = it.soft_blocks;
                            rec[r].hb = it.hard_blocks;
                            rec[r].si = it.soft_inodes;
                            rec[r].hi = it.hard_inodes;
                            if (rec[r].ub <= rec[r].sb || rec[r].sb == 0)
                                rec[r].db = 0;
                            if (rec[r].ui <= rec[r].si || rec[r].si == 0)
                                rec[r].di = 0;
                        end
                    end
                end
                OP_GET_USER, OP_GET_GROUP: begin
                    if (it.operation == OP_GET_USER)
                        r = find(0, it.user_id, 0);
                    else
                        r = find(1, it.group_id, 0);
                    if (r >= 0)
                    begin
                        rep.record_found    = 1'b1;
                        rep.used_blocks     = rec[r].ub;
                        rep.used_inodes     = rec[r].ui;
                        rep.out_soft_blocks = rec[r].sb;
                        rep.out_hard_blocks = rec[r].hb;
                        rep.out_soft_inodes = rec[r].si;
                        rep.out_hard_inodes = rec[r].hi;
                        rep.block_deadline  = rec[r].db;
                        rep.inode_deadline  = rec[r].di;
                    end
                end
                OP_UNDO_RES: begin
                    u = find(0, it.user_id, 0);
                    if (u >= 0)
                        credit(u, b, n);
                    g = find(1, it.group_id, 0);
                    if (g >= 0)
                        credit(g, b, n);
                end
                OP_UNDO_XFER: begin
                    ou = find(0, it.user_id, 1);
                    og = find(1, it.group_id, 1);
                    nu = find(0, it.new_user_id, 0);
                    ng = find(1, it.new_group_id, 0);
                    if (it.user_id != it.new_user_id && ou >= 0 && nu >= 0 && covers(nu, b, n))
                    begin
                        credit(nu, b, n);
                        charge(ou, b, n, now);
                    end
                    if (it.group_id != it.new_group_id && og >= 0 && ng >= 0 &&
                        covers(ng, b, n))
                    begin
                        credit(ng, b, n);
                        charge(og, b, n, now);
                    end
                end
                default: st = ST_INVALID;
            endcase
            rep.status = st;
            pending_replies.push_back(rep);
        endfunction

        function void field_cmp(string fname, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t mismatch %s: expected %h got %h", $time, fname, want, got);
            end
        endfunction

        function void check_reply(out_item_t got);
            out_item_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t unexpected reply transaction: status %0d", $time, got.status);
                return;
            end
            want = pending_replies.pop_front();
            replies_seen++;
            if (want.status == ST_QUOTA)
                refusals++;
            if (want.record_found)
                reads_hit++;
            field_cmp("status", want.status, got.status);
            field_cmp("record_found", want.record_found, got.record_found);
            field_cmp("used_blocks", want.used_blocks, got.used_blocks);
            field_cmp("used_inodes", want.used_inodes, got.used_inodes);
            field_cmp("soft_blocks", want.out_soft_blocks, got.out_soft_blocks);
            field_cmp("hard_blocks", want.out_hard_blocks, got.out_hard_blocks);
            field_cmp("soft_inodes", want.out_soft_inodes, got.out_soft_inodes);
            field_cmp("hard_inodes", want.out_hard_inodes, got.out_hard_inodes);
            field_cmp("block_deadline", want.block_deadline, got.block_deadline);
            field_cmp("inode_deadline", want.inode_deadline, got.inode_deadline);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    quota_ledger ledger;
    longint      cycles;
    logic [31:0] id_pool[20];
    logic [63:0] clock_secs;
    int          settings_used;

    usage_quota_table #(.RECORDS_PER_TYPE(NREC)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[usage_quota_table] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: a randomly redrawn mode picks no stall, random stalls or stall runs
    int stall_mode;
    int stall_run;
    always @(posedge clk)
    begin
        if (cycles % 256 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
        end
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 9) < 3);
        else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
        begin
            stall_run <= $urandom_range(1, 20);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Signals are stable between falling and rising edge, so sample there
    always @(negedge clk)
        if (rst_n && out_valid && !out_stall)
            ledger.check_reply(out_data);

    task automatic send_op(in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
            begin
                ledger.note_operation(it);
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    task automatic idle_cycles(int gap);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
            begin
                ledger.write_reg(idx, val);
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_amount();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 20);
        if (pick < 85)
            return $urandom_range(0, 1000);
        if (pick < 95)
            return rand64();
        return MAX64 - $urandom_range(0, 3);
    endfunction

    function automatic in_item_t directed(op_t op, int u, int g, int nu, int ng,
                                          logic [63:0] b, logic [63:0] n,
                                          logic [63:0] now);
        in_item_t it;
        it = '0;
        it.operation = op;
        it.user_id = id_pool[u];
        it.group_id = id_pool[g];
        it.new_user_id = id_pool[nu];
        it.new_group_id = id_pool[ng];
        it.block_count = b;
        it.inode_count = n;
        it.time_now = now;
        return it;
    endfunction

    function automatic in_item_t random_op();
        in_item_t it;
        int       pick;
        logic [63:0] lim;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            it.operation = OP_RESERVE;
        else if (pick < 32)
            it.operation = OP_RELEASE;
        else if (pick < 44)
            it.operation = OP_TRANSFER;
        else if (pick < 51)
            it.operation = OP_REBUILD;
        else if (pick < 57)
            it.operation = OP_SET_USER;
        else if (pick < 63)
            it.operation = OP_SET_GROUP;
        else if (pick < 70)
            it.operation = OP_GET_USER;
        else if (pick < 77)
            it.operation = OP_GET_GROUP;
        else if (pick < 86)
            it.operation = OP_UNDO_RES;
        else if (pick < 96)
            it.operation = OP_UNDO_XFER;
        else
            it.operation = 4'($urandom_range(10, 15));
        it.user_id = id_pool[$urandom_range(0, 19)];
        it.group_id = id_pool[$urandom_range(0, 19)];
        it.new_user_id = ($urandom_range(0, 3) == 0) ? it.user_id : id_pool[$urandom_range(0, 19)];
        it.new_group_id = ($urandom_range(0, 3) == 0) ? it.group_id
                                                      : id_pool[$urandom_range(0, 19)];
        it.block_count = rand_amount();
        it.inode_count = rand_amount();
        clock_secs += $urandom_range(0, 40);
        it.time_now = ($urandom_range(0, 19) == 0) ? rand64() : clock_secs;
        if (it.operation == OP_SET_USER || it.operation == OP_SET_GROUP)
        begin
            lim = $urandom_range(0, 60);
            it.soft_blocks = ($urandom_range(0, 4) == 0) ? 64'd0 : lim;
            it.hard_blocks = ($urandom_range(0, 4) == 0) ? 64'd0 : lim + $urandom_range(0, 60);
            lim = $urandom_range(0, 60);
            it.soft_inodes = ($urandom_range(0, 4) == 0) ? 64'd0 : lim;
            it.hard_inodes = ($urandom_range(0, 4) == 0) ? 64'd0 : lim + $urandom_range(0, 60);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                it.soft_blocks = rand64();
                it.hard_blocks = rand64();
            end
            else if (pick == 1)
            begin
                it.soft_inodes = rand64();
                it.hard_inodes = rand64();
            end
        end
        else
        begin
            // unused by the operation; toggles the bits anyway
            it.soft_blocks = rand64();
            it.hard_blocks = rand64();
            it.soft_inodes = rand64();
            it.hard_inodes = rand64();
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_op(random_op());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 30));
        end
    endtask

    initial
    begin
        in_item_t it;
        ledger = new();
        cycles = 0;
        stall_mode = 0;
        stall_run = 0;
        clock_secs = 64'd1000;
        settings_used = 1;
        id_pool[0] = 32'd0;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 20; i++)
            id_pool[i] = (i < 12) ? 32'(i) : $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_USER_ENF, 64'd1);
        write_reg(CFG_GROUP_ENF, 64'd1);
        write_reg(CFG_GRACE, 64'd100);

        // directed: limits, soft crossing and grace expiry, hard limit, errors
        it = directed(OP_SET_USER, 0, 0, 0, 0, 0, 0, 0);
        it.soft_blocks = 10; it.hard_blocks = 20; it.soft_inodes = 5; it.hard_inodes = 8;
        send_op(it);
        it.operation = OP_SET_GROUP;
        send_op(it);
        it.operation = OP_SET_USER;
        it.soft_blocks = 30;
        send_op(it);                                            // soft above hard
        send_op(directed(OP_RESERVE, 0, 0, 0, 0, 15, 3, 1000));
        send_op(directed(OP_GET_USER, 0, 0, 0, 0, 0, 0, 0));
        send_op(directed(OP_RESERVE, 0, 0, 0, 0, 1, 0, 1200)); // grace over
        send_op(directed(OP_RESERVE, 0, 0, 0, 0, 10, 0, 1050)); // over hard
        send_op(directed(OP_RELEASE, 0, 0, 0, 0, 10, 1, 1300));
        send_op(directed(OP_GET_GROUP, 0, 0, 0, 0, 0, 0, 0));
        send_op(directed(OP_RELEASE, 0, 0, 0, 0, 100, 0, 1300)); // more than held
        send_op(directed(OP_TRANSFER, 0, 0, 2, 3, 2, 1, 1400));
        send_op(directed(OP_TRANSFER, 2, 3, 2, 3, 1, 1, 1400)); // same owner
        send_op(directed(OP_UNDO_XFER, 0, 0, 2, 3, 2, 1, 1500));
        send_op(directed(OP_UNDO_RES, 0, 4, 0, 0, 3, 1, 1500)); // absent group
        send_op(directed(OP_REBUILD, 0, 0, 0, 0, MAX64, 0, 1600)); // would overflow
        send_op(directed(OP_RESERVE, 0, 0, 0, 0, MAX64, MAX64, MAX64));
        send_op(directed(OP_GET_USER, 1, 1, 0, 0, 0, 0, 0));  // absent record
        it = directed(OP_GET_USER, 0, 0, 0, 0, 0, 0, 0);
        it.operation = 4'hF;
        send_op(it);                                            // unknown code
        it = directed(OP_SET_GROUP, 5, 5, 0, 0, 0, 0, 0);
        it.soft_blocks = MAX64; it.hard_blocks = 0; it.soft_inodes = MAX64;
        it.hard_inodes = MAX64;
        send_op(it);
        send_op(directed(OP_GET_GROUP, 5, 5, 0, 0, 0, 0, 0));
        drain();

        random_phase(110);
        drain();
        write_reg(CFG_GROUP_ENF, 64'd0);
        write_reg(CFG_GRACE, 64'd1);
        settings_used++;
        random_phase(110);
        drain();
        write_reg(CFG_USER_ENF, 64'd0);
        write_reg(CFG_GROUP_ENF, 64'd1);
        write_reg(CFG_GRACE, MAX64);
        settings_used++;
        random_phase(110);
        drain();
        write_reg(CFG_USER_ENF, 64'd0);
        write_reg(CFG_GROUP_ENF, 64'd0);
        write_reg(CFG_GRACE, 64'd0);                            // ignored
        write_reg(2'd3, rand64());                              // no such register
        settings_used++;
        random_phase(110);
        drain();
        write_reg(CFG_USER_ENF, 64'd1);
        write_reg(CFG_GROUP_ENF, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_GRACE, 64'd25);
        settings_used++;
        random_phase(110);
        drain();

        $display("checked %0d replies under %0d register settings", ledger.replies_seen,
                 settings_used);
        $display("%0d quota refusals, %0d reads of existing records", ledger.refusals,
                 ledger.reads_hit);
        if (ledger.errors == 0 && ledger.pending_replies.size() == 0)
            $display("[usage_quota_table] OK");
        else
            $display("[usage_quota_table] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
